// ===== src/radix_text_to_wide_integer_macros.svh =====
// assertion helpers for the radix text converter
`ifndef RADIX_TEXT_TO_WIDE_INTEGER_MACROS_SVH
`define RADIX_TEXT_TO_WIDE_INTEGER_MACROS_SVH

// same-cycle implication, checked outside reset
`define RTWI_ASSERT_IMP(label, clk, rst_n, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error(msg);

// next-cycle implication, checked outside reset
`define RTWI_ASSERT_NXT(label, clk, rst_n, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

// ===== src/rtwi_pkg.sv =====
`timescale 1ns / 1ps

package rtwi_pkg;

	localparam int LIMB_W           = 32;
	localparam int WORD_W           = 64;
	localparam int MAX_BITS_DEFAULT = 128;
	localparam int CARRY_W          = 4;
	localparam int MUL_W            = 5;
	localparam int TOP_W            = 5;

	localparam logic [7:0] RADIX_RESET       = 8'd10;
	localparam logic [7:0] VALUE_WIDTH_RESET = 8'd128;
	localparam logic [7:0] RADIX_MIN         = 8'd2;
	localparam logic [7:0] RADIX_MAX         = 8'd16;
	localparam logic [7:0] CHAR_UNDERSCORE   = 8'h5F;

	localparam logic [7:0] REG_RADIX       = 8'd0;
	localparam logic [7:0] REG_VALUE_WIDTH = 8'd1;

	localparam logic [2:0] ST_OK        = 3'd0;
	localparam logic [2:0] ST_BAD_RADIX = 3'd1;
	localparam logic [2:0] ST_BAD_DIGIT = 3'd2;
	localparam logic [2:0] ST_OVERFLOW  = 3'd3;
	localparam logic [2:0] ST_NO_DIGITS = 3'd4;

	// control for one limb step of the shared multiply-add
	typedef struct packed {
		logic             active;     // limb lies below the effective width
		logic             top_check;  // limb is the partial top limb
		logic [TOP_W-1:0] top;        // bit position of the width inside that limb
	} mac_ctl_t;

	// decoded character
	typedef struct packed {
		logic       is_hex;
		logic [3:0] value;
	} digit_t;

endpackage

// ===== src/rtwi_char_decode.sv =====
`timescale 1ns / 1ps

module rtwi_char_decode import rtwi_pkg::*; (
	input  logic [7:0] character,
	output digit_t     digit
);

	always_comb begin
		digit.is_hex = 1'b1;
		digit.value  = 4'd0;
		if (character >= 8'h30 && character <= 8'h39) begin
			digit.value = 4'(character - 8'h30);
		end else if (character >= 8'h61 && character <= 8'h66) begin
			digit.value = 4'(character - 8'h61 + 8'd10);
		end else if (character >= 8'h41 && character <= 8'h46) begin
			digit.value = 4'(character - 8'h41 + 8'd10);
		end else begin
			digit.is_hex = 1'b0;
		end
	end

endmodule

// ===== src/rtwi_limb_mac.sv =====
`timescale 1ns / 1ps

module rtwi_limb_mac import rtwi_pkg::*; (
	input  logic [LIMB_W-1:0]  limb_in,
	input  logic [MUL_W-1:0]   mul,
	input  logic [CARRY_W-1:0] carry_in,
	input  mac_ctl_t           ctl,
	output logic [LIMB_W-1:0]  limb_out,
	output logic [CARRY_W-1:0] carry_out,
	output logic               ovf
);

	localparam int P_W = LIMB_W + CARRY_W;

	logic [P_W-1:0] prod;

	assign prod = P_W'(limb_in) * P_W'(mul) + P_W'(carry_in);

	always_comb begin
		if (ctl.active) begin
			limb_out  = prod[LIMB_W-1:0];
			carry_out = prod[P_W-1:LIMB_W];
			ovf       = ctl.top_check && ((prod[LIMB_W-1:0] >> ctl.top) != '0);
		end else begin
			// limbs above the width are left alone but must be zero
			limb_out  = limb_in;
			carry_out = carry_in;
			ovf       = (limb_in != '0);
		end
	end

endmodule

// ===== src/radix_text_to_wide_integer.sv =====
`timescale 1ns / 1ps

// Converts a numeric literal, one ASCII character per item with end_of_text on the
// last, into an unsigned integer of up to MAX_BITS bits in the radix held in the radix
// register (2 to 16, hex letters in either case, underscores skipped). On the last
// character it gives a status (ok, bad radix, bad digit, overflow, no digits) and the
// value as one or two 64-bit words; on error a single zero word. A digit is accepted and
// then worked through all LIMB_COUNT limbs, one 32-bit limb multiply-add per cycle
// through the single shared multiply-add unit, while the input stalls; an underscore or
// a character after an error is only accepted. The last character then passes through
// the finish state to hand its words to the output register, and waits there while
// the previous literal's words are still stalled there. Configuration writes are
// always taken and should arrive only while the block is idle.
module radix_text_to_wide_integer import rtwi_pkg::*; #(
	parameter int MAX_BITS = MAX_BITS_DEFAULT
) (
	input  logic        clk,
	input  logic        arst_n,
	// configuration
	input  logic        cfg_valid,
	output logic        cfg_ready,
	input  logic [7:0]  cfg_index,
	input  logic [7:0]  cfg_data,
	// character items
	input  logic        in_valid,
	output logic        in_stall,
	input  logic [7:0]  character,
	input  logic        end_of_text,
	// result items
	output logic        out_valid,
	input  logic        out_stall,
	output logic [2:0]  status,
	output logic [63:0] value_word,
	output logic        word_index,
	output logic        last_word
);

	localparam int LIMB_COUNT = (MAX_BITS + LIMB_W - 1) / LIMB_W;
	localparam int IW         = (LIMB_COUNT > 1) ? $clog2(LIMB_COUNT) : 1;
	localparam int WW         = $clog2(MAX_BITS + 1);
	localparam int VIEW_LIMBS = 4;

	typedef enum logic [2:0] {
		S_IDLE   = 3'b001,
		S_CALC   = 3'b010,
		S_FINISH = 3'b100
	} state_t;

	state_t state_q;

	logic [7:0]         radix_q;
	logic [7:0]         value_width_q;
	logic [LIMB_W-1:0]  acc_q [LIMB_COUNT];
	logic [IW-1:0]      idx_q;
	logic [CARRY_W-1:0] carry_q;
	logic               ovf_q;
	logic               seen_q;
	logic [2:0]         error_q;
	logic               last_q;

	logic               out_valid_q;
	logic [2:0]         out_status_q;
	logic [WORD_W-1:0]  out_word_q;
	logic               out_index_q;
	logic               out_last_q;
	logic               pend_q;
	logic [WORD_W-1:0]  pend_word_q;

	// configuration registers, the port never pushes back
	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			radix_q       <= RADIX_RESET;
			value_width_q <= VALUE_WIDTH_RESET;
		end else if (cfg_valid) begin
			if (cfg_index == REG_RADIX) begin
				radix_q <= cfg_data;
			end else if (cfg_index == REG_VALUE_WIDTH) begin
				value_width_q <= cfg_data;
			end
		end
	end

	// effective width clamped to 1..MAX_BITS and the limbs it covers
	logic [WW-1:0] eff_w;
	logic [WW-1:0] used;
	logic [WW-1:0] idx_ext;
	logic          radix_ok;

	always_comb begin
		if (value_width_q == 8'd0) begin
			eff_w = WW'(1);
		end else if (16'(value_width_q) > 16'(MAX_BITS)) begin
			eff_w = WW'(MAX_BITS);
		end else begin
			eff_w = WW'(value_width_q);
		end
	end

	assign used     = (eff_w >> 5) + WW'(eff_w[TOP_W-1:0] != '0);
	assign idx_ext  = WW'(idx_q);
	assign radix_ok = (radix_q >= RADIX_MIN) && (radix_q <= RADIX_MAX);

	// character decode
	digit_t digit;

	rtwi_char_decode u_decode (
		.character (character),
		.digit     (digit)
	);

	// shared limb multiply-add
	mac_ctl_t           mac_ctl;
	logic [LIMB_W-1:0]  mac_limb;
	logic [CARRY_W-1:0] mac_carry;
	logic               mac_ovf;

	assign mac_ctl.active    = idx_ext < used;
	assign mac_ctl.top_check = (idx_ext + WW'(1) == used) && (eff_w[TOP_W-1:0] != '0);
	assign mac_ctl.top       = eff_w[TOP_W-1:0];

	rtwi_limb_mac u_mac (
		.limb_in   (acc_q[idx_q]),
		.mul       (radix_q[MUL_W-1:0]),
		.carry_in  (carry_q),
		.ctl       (mac_ctl),
		.limb_out  (mac_limb),
		.carry_out (mac_carry),
		.ovf       (mac_ovf)
	);

	logic calc_done;
	logic calc_ovf;

	assign calc_done = (idx_q == IW'(LIMB_COUNT - 1));
	// a carry left over after the top used limb is an overflow as well
	assign calc_ovf  = ovf_q || mac_ovf || (mac_carry != '0);

	// value words, limbs past the store read as zero
	logic [VIEW_LIMBS*LIMB_W-1:0] view;

	for (genvar j = 0; j < VIEW_LIMBS; j++) begin : g_view
		if (j < LIMB_COUNT) begin : g_limb
			assign view[j*LIMB_W +: LIMB_W] = acc_q[j];
		end else begin : g_zero
			assign view[j*LIMB_W +: LIMB_W] = '0;
		end
	end

	logic [2:0] fin_status;

	always_comb begin
		priority if (error_q != ST_OK) begin
			fin_status = error_q;
		end else if (!radix_ok) begin
			fin_status = ST_BAD_RADIX;
		end else if (!seen_q) begin
			fin_status = ST_NO_DIGITS;
		end else begin
			fin_status = ST_OK;
		end
	end

	logic in_take;
	logic out_take;
	logic can_load;
	logic fin_load;

	assign in_stall = (state_q != S_IDLE);
	assign in_take  = in_valid && !in_stall;
	assign out_take = out_valid_q && !out_stall;
	assign can_load = !pend_q && (!out_valid_q || !out_stall);
	assign fin_load = (state_q == S_FINISH) && can_load;

	// sequencer and accumulator
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
			idx_q   <= '0;
			carry_q <= '0;
			ovf_q   <= 1'b0;
			seen_q  <= 1'b0;
			error_q <= ST_OK;
			last_q  <= 1'b0;
			for (int i = 0; i < LIMB_COUNT; i++) begin
				acc_q[i] <= '0;
			end
		end else begin
			unique case (state_q)
				S_IDLE: begin
					if (in_take) begin
						last_q  <= end_of_text;
						state_q <= end_of_text ? S_FINISH : S_IDLE;
						if (error_q == ST_OK) begin
							if (!radix_ok) begin
								error_q <= ST_BAD_RADIX;
							end else if (character != CHAR_UNDERSCORE) begin
								if (!digit.is_hex || 8'(digit.value) >= radix_q) begin
									error_q <= ST_BAD_DIGIT;
								end else begin
									// digit value rides in as the first carry
									seen_q  <= 1'b1;
									carry_q <= digit.value;
									idx_q   <= '0;
									ovf_q   <= 1'b0;
									state_q <= S_CALC;
								end
							end
						end
					end
				end
				S_CALC: begin
					acc_q[idx_q] <= mac_limb;
					carry_q      <= mac_carry;
					ovf_q        <= ovf_q || mac_ovf;
					if (calc_done) begin
						if (calc_ovf) begin
							error_q <= ST_OVERFLOW;
						end
						state_q <= last_q ? S_FINISH : S_IDLE;
					end else begin
						idx_q <= idx_q + IW'(1);
					end
				end
				S_FINISH: begin
					if (can_load) begin
						// literal handed over, start clean
						for (int i = 0; i < LIMB_COUNT; i++) begin
							acc_q[i] <= '0;
						end
						seen_q  <= 1'b0;
						error_q <= ST_OK;
						state_q <= S_IDLE;
					end
				end
				default: begin
					state_q <= S_IDLE;
				end
			endcase
		end
	end

	// output register plus one pending upper word
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
			pend_q      <= 1'b0;
		end else if (fin_load) begin
			out_valid_q <= 1'b1;
			pend_q      <= (fin_status == ST_OK) && (eff_w > WW'(WORD_W));
		end else if (out_take) begin
			out_valid_q <= pend_q;
			pend_q      <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (fin_load) begin
			out_status_q <= fin_status;
			out_index_q  <= 1'b0;
			pend_word_q  <= view[2*WORD_W-1:WORD_W];
			if (fin_status != ST_OK) begin
				out_word_q <= '0;
				out_last_q <= 1'b1;
			end else begin
				out_word_q <= view[WORD_W-1:0];
				out_last_q <= !(eff_w > WW'(WORD_W));
			end
		end else if (out_take && pend_q) begin
			out_status_q <= ST_OK;
			out_word_q   <= pend_word_q;
			out_index_q  <= 1'b1;
			out_last_q   <= 1'b1;
		end
	end

	assign out_valid  = out_valid_q;
	assign status     = out_status_q;
	assign value_word = out_word_q;
	assign word_index = out_index_q;
	assign last_word  = out_last_q;

endmodule

// ===== src/rtwi_checker.sv =====
`timescale 1ns / 1ps

`include "radix_text_to_wide_integer_macros.svh"

module rtwi_checker import rtwi_pkg::*; (
	input logic        clk,
	input logic        arst_n,
	input logic        out_valid,
	input logic        out_stall,
	input logic [2:0]  status,
	input logic [63:0] value_word,
	input logic        word_index,
	input logic        last_word
);

	// a stalled item holds
	`RTWI_ASSERT_NXT(a_out_hold, clk, arst_n, out_valid && out_stall,
		out_valid && $stable(value_word) && $stable(status) && $stable(word_index),
		"stalled result item changed")

	// error results are a single zero word
	`RTWI_ASSERT_IMP(a_err_single, clk, arst_n, out_valid && status != ST_OK,
		value_word == 64'd0 && word_index == 1'b0 && last_word,
		"error result item not a single zero word")

	// the upper word always closes a two-word value, and only an ok value has one
	`RTWI_ASSERT_IMP(a_upper_last, clk, arst_n, out_valid && word_index,
		last_word && status == ST_OK,
		"upper word item is not final or not ok")

	// a non-final word is always the lower word of an ok value
	`RTWI_ASSERT_IMP(a_lower_ok, clk, arst_n, out_valid && !last_word,
		word_index == 1'b0 && status == ST_OK,
		"non-final result item is not an ok lower word")

endmodule

bind radix_text_to_wide_integer rtwi_checker u_rtwi_checker (.*);
